// ===== rtl/core/rv64im_execute_unit_core_defines.svh =====
// ----------------------------------------------------------------------------
// rv64im_execute_unit_core_defines.svh
// Assertion macros used by the execute unit checker.
// ----------------------------------------------------------------------------
`ifndef RV64IM_EXECUTE_UNIT_CORE_DEFINES_SVH
`define RV64IM_EXECUTE_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define RV64EX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define RV64EX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rv64ex_pkg.sv =====
// ----------------------------------------------------------------------------
// rv64ex_pkg
// Types, operation codes and helpers for the RV64IM execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rv64ex_pkg;

	localparam int XLEN      = 64;
	localparam int DIV_STEPS = XLEN;

	typedef enum logic [5:0] {
		CMD_ADD   = 6'd0,  CMD_MUL   = 6'd1,  CMD_SUB   = 6'd2,  CMD_SLL   = 6'd3,
		CMD_MULH  = 6'd4,  CMD_SLT   = 6'd5,  CMD_XOR   = 6'd6,  CMD_DIV   = 6'd7,
		CMD_SRL   = 6'd8,  CMD_SRA   = 6'd9,  CMD_OR    = 6'd10, CMD_REM   = 6'd11,
		CMD_AND   = 6'd12, CMD_ADDW  = 6'd13, CMD_SUBW  = 6'd14, CMD_MULW  = 6'd15,
		CMD_DIVW  = 6'd16, CMD_REMW  = 6'd17, CMD_SLLW  = 6'd18, CMD_SRLW  = 6'd19,
		CMD_SRAW  = 6'd20, CMD_LOAD  = 6'd21, CMD_ADDI  = 6'd22, CMD_SLLI  = 6'd23,
		CMD_SRLI  = 6'd24, CMD_SRAI  = 6'd25, CMD_SLLIW = 6'd26, CMD_SLTI  = 6'd27,
		CMD_XORI  = 6'd28, CMD_SRLIW = 6'd29, CMD_SRAIW = 6'd30, CMD_ORI   = 6'd31,
		CMD_ANDI  = 6'd32, CMD_ADDIW = 6'd33, CMD_JALR  = 6'd34, CMD_STORE = 6'd35,
		CMD_BEQ   = 6'd36, CMD_BNE   = 6'd37, CMD_BLT   = 6'd38, CMD_BGE   = 6'd39,
		CMD_BLTU  = 6'd40, CMD_BGEU  = 6'd41, CMD_AUIPC = 6'd42, CMD_LUI   = 6'd43,
		CMD_JAL   = 6'd44
	} cmd_t;

	// Where the final result comes from.
	typedef enum logic [2:0] {
		SEL_ALU, SEL_MUL, SEL_MULH, SEL_MULW, SEL_DIV, SEL_REM
	} sel_t;

	// Sideband that rides along the divider pipe.
	typedef struct packed {
		logic [XLEN-1:0] result;
		logic            taken;
		sel_t            sel;
		logic            negq;
		logic            negr;
		logic            dz;
		logic            word;
	} side_t;

	typedef struct packed {
		logic [XLEN-1:0] rem;
		logic [XLEN-1:0] qd;   // dividend bits shifting out, quotient bits in
		logic [XLEN-1:0] dvs;
		side_t           side;
	} div_stage_t;

	function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] x);
		sext32 = {{32{x[31]}}, x[31:0]};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rv64ex_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rv64ex_div_pipe
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64ex_div_pipe (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   adv,
	input  wire logic                   in_valid,
	input  wire rv64ex_pkg::div_stage_t in_stage,
	output logic                        out_valid,
	output rv64ex_pkg::div_stage_t      out_stage
);

	rv64ex_pkg::div_stage_t st_q  [0:rv64ex_pkg::DIV_STEPS];
	logic                   vld_q [0:rv64ex_pkg::DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= rv64ex_pkg::DIV_STEPS; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i <= rv64ex_pkg::DIV_STEPS; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_q[0] <= in_stage;
		end
	end

	for (genvar k = 1; k <= rv64ex_pkg::DIV_STEPS; k++) begin : g_step
		logic [rv64ex_pkg::XLEN:0] r2;
		logic [rv64ex_pkg::XLEN:0] diff;
		logic                      ge;
		rv64ex_pkg::div_stage_t    nxt;

		always_comb begin
			r2   = {st_q[k-1].rem, st_q[k-1].qd[rv64ex_pkg::XLEN-1]};
			diff = r2 - {1'b0, st_q[k-1].dvs};
			ge   = !diff[rv64ex_pkg::XLEN];
			nxt  = st_q[k-1];
			nxt.rem = ge ? diff[rv64ex_pkg::XLEN-1:0] : r2[rv64ex_pkg::XLEN-1:0];
			nxt.qd  = {st_q[k-1].qd[rv64ex_pkg::XLEN-2:0], ge};
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				st_q[k] <= nxt;
			end
		end
	end

	assign out_valid = vld_q[rv64ex_pkg::DIV_STEPS];
	assign out_stage = st_q[rv64ex_pkg::DIV_STEPS];

endmodule

`default_nettype wire

// ===== rtl/core/rv64im_execute_unit_core.sv =====
// ----------------------------------------------------------------------------
// rv64im_execute_unit_core
// RV64IM execute stage: ALU, branch compare, pipelined multiply and divide.
// ----------------------------------------------------------------------------
// Every command runs through the whole pipe; the 64-stage divider pipe sets the depth.
// Throughput: one request per cycle while req_stall is low.
// The whole pipe advances together; req_stall follows rsp_stall only while
// the output register is full.
// Reset: arst_n clears all valid bits; payload registers are not reset.
`default_nettype none

module rv64im_execute_unit_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [5:0]  cmd,
	input  wire logic [63:0] operand_a,
	input  wire logic [63:0] operand_b,
	input  wire logic [31:0] imm,
	input  wire logic [63:0] pc,
	// response channel
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [63:0]      result,
	output logic             branch_taken
);

	// Global advance: the output register is empty or being drained.
	logic adv;
	logic rsp_valid_q;
	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = !adv;

	// ---------------- Stage 1: capture request ----------------
	logic              valid_s1;
	rv64ex_pkg::cmd_t  cmd_s1;
	logic [63:0]       a_s1, b_s1, c_s1, pc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= rv64ex_pkg::cmd_t'(cmd);
			a_s1   <= operand_a;
			b_s1   <= operand_b;
			c_s1   <= {{32{imm[31]}}, imm};
			pc_s1  <= pc;
		end
	end

	// ---------------- Stage 2: ALU, partial products, divide prep ----------------
	logic [63:0]      alu_res;
	logic             alu_taken;
	rv64ex_pkg::sel_t alu_sel;
	logic [63:0]      pc_tgt;
	logic [63:0]      dx, dy;
	logic             div_word;

	always_comb begin
		pc_tgt    = pc_s1 + c_s1;
		alu_res   = '0;
		alu_taken = 1'b0;
		alu_sel   = rv64ex_pkg::SEL_ALU;
		div_word  = 1'b0;
		case (cmd_s1)
			rv64ex_pkg::CMD_ADD:   alu_res = a_s1 + b_s1;
			rv64ex_pkg::CMD_MUL:   alu_sel = rv64ex_pkg::SEL_MUL;
			rv64ex_pkg::CMD_SUB:   alu_res = a_s1 - b_s1;
			rv64ex_pkg::CMD_SLL:   alu_res = a_s1 << b_s1[5:0];
			rv64ex_pkg::CMD_MULH:  alu_sel = rv64ex_pkg::SEL_MULH;
			rv64ex_pkg::CMD_SLT:   alu_res = {63'd0, $signed(a_s1) < $signed(b_s1)};
			rv64ex_pkg::CMD_XOR:   alu_res = a_s1 ^ b_s1;
			rv64ex_pkg::CMD_DIV:   alu_sel = rv64ex_pkg::SEL_DIV;
			rv64ex_pkg::CMD_SRL:   alu_res = a_s1 >> b_s1[5:0];
			rv64ex_pkg::CMD_SRA:   alu_res = 64'($signed(a_s1) >>> b_s1[5:0]);
			rv64ex_pkg::CMD_OR:    alu_res = a_s1 | b_s1;
			rv64ex_pkg::CMD_REM:   alu_sel = rv64ex_pkg::SEL_REM;
			rv64ex_pkg::CMD_AND:   alu_res = a_s1 & b_s1;
			rv64ex_pkg::CMD_ADDW:  alu_res = rv64ex_pkg::sext32(a_s1 + b_s1);
			rv64ex_pkg::CMD_SUBW:  alu_res = rv64ex_pkg::sext32(a_s1 - b_s1);
			rv64ex_pkg::CMD_MULW:  alu_sel = rv64ex_pkg::SEL_MULW;
			rv64ex_pkg::CMD_DIVW: begin
				alu_sel  = rv64ex_pkg::SEL_DIV;
				div_word = 1'b1;
			end
			rv64ex_pkg::CMD_REMW: begin
				alu_sel  = rv64ex_pkg::SEL_REM;
				div_word = 1'b1;
			end
			rv64ex_pkg::CMD_SLLW:  alu_res = rv64ex_pkg::sext32(a_s1 << b_s1[4:0]);
			rv64ex_pkg::CMD_SRLW:
				alu_res = rv64ex_pkg::sext32({32'd0, a_s1[31:0]} >> b_s1[4:0]);
			rv64ex_pkg::CMD_SRAW:
				alu_res = 64'($signed(rv64ex_pkg::sext32(a_s1)) >>> b_s1[4:0]);
			rv64ex_pkg::CMD_LOAD,
			rv64ex_pkg::CMD_ADDI,
			rv64ex_pkg::CMD_STORE: alu_res = a_s1 + c_s1;
			rv64ex_pkg::CMD_SLLI:  alu_res = a_s1 << c_s1[5:0];
			rv64ex_pkg::CMD_SRLI:  alu_res = a_s1 >> c_s1[5:0];
			rv64ex_pkg::CMD_SRAI:  alu_res = 64'($signed(a_s1) >>> c_s1[5:0]);
			rv64ex_pkg::CMD_SLLIW: alu_res = rv64ex_pkg::sext32(a_s1 << c_s1[4:0]);
			rv64ex_pkg::CMD_SLTI:  alu_res = {63'd0, $signed(a_s1) < $signed(c_s1)};
			rv64ex_pkg::CMD_XORI:  alu_res = a_s1 ^ c_s1;
			rv64ex_pkg::CMD_SRLIW:
				alu_res = rv64ex_pkg::sext32({32'd0, a_s1[31:0]} >> c_s1[4:0]);
			rv64ex_pkg::CMD_SRAIW:
				alu_res = 64'($signed(rv64ex_pkg::sext32(a_s1)) >>> c_s1[4:0]);
			rv64ex_pkg::CMD_ORI:   alu_res = a_s1 | c_s1;
			rv64ex_pkg::CMD_ANDI:  alu_res = a_s1 & c_s1;
			rv64ex_pkg::CMD_ADDIW: alu_res = rv64ex_pkg::sext32(a_s1 + c_s1);
			rv64ex_pkg::CMD_JALR:  alu_res = (a_s1 + c_s1) & ~64'd1;
			rv64ex_pkg::CMD_BEQ: begin
				alu_taken = (a_s1 == b_s1);
				alu_res   = pc_tgt;
			end
			rv64ex_pkg::CMD_BNE: begin
				alu_taken = (a_s1 != b_s1);
				alu_res   = pc_tgt;
			end
			rv64ex_pkg::CMD_BLT: begin
				alu_taken = $signed(a_s1) < $signed(b_s1);
				alu_res   = pc_tgt;
			end
			rv64ex_pkg::CMD_BGE: begin
				alu_taken = !($signed(a_s1) < $signed(b_s1));
				alu_res   = pc_tgt;
			end
			rv64ex_pkg::CMD_BLTU: begin
				alu_taken = (a_s1 < b_s1);
				alu_res   = pc_tgt;
			end
			rv64ex_pkg::CMD_BGEU: begin
				alu_taken = (a_s1 >= b_s1);
				alu_res   = pc_tgt;
			end
			rv64ex_pkg::CMD_AUIPC,
			rv64ex_pkg::CMD_JAL:   alu_res = pc_tgt;
			rv64ex_pkg::CMD_LUI:   alu_res = c_s1;
			default:               alu_res = '0;   // unused codes
		endcase
		// divide operands: W forms divide the sign-extended low words
		dx = div_word ? rv64ex_pkg::sext32(a_s1) : a_s1;
		dy = div_word ? rv64ex_pkg::sext32(b_s1) : b_s1;
	end

	logic             valid_s2;
	logic [63:0]      res_s2;
	logic             taken_s2;
	rv64ex_pkg::sel_t sel_s2;
	logic [63:0]      a_s2, b_s2;
	logic [63:0]      ll_s2, lh_s2, hl_s2, hh_s2;
	logic [63:0]      ma_s2, mb_s2;
	logic             negq_s2, negr_s2, dz_s2, word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2   <= alu_res;
			taken_s2 <= alu_taken;
			sel_s2   <= alu_sel;
			a_s2     <= a_s1;
			b_s2     <= b_s1;
			// four 32x32 unsigned partial products
			ll_s2    <= a_s1[31:0]  * b_s1[31:0];
			lh_s2    <= a_s1[31:0]  * b_s1[63:32];
			hl_s2    <= a_s1[63:32] * b_s1[31:0];
			hh_s2    <= a_s1[63:32] * b_s1[63:32];
			ma_s2    <= dx[63] ? (64'd0 - dx) : dx;
			mb_s2    <= dy[63] ? (64'd0 - dy) : dy;
			negq_s2  <= dx[63] ^ dy[63];
			negr_s2  <= dx[63];
			dz_s2    <= (dy == 64'd0);
			word_s2  <= div_word;
		end
	end

	// ---------------- Stage 3: partial product sums ----------------
	logic             valid_s3;
	logic [63:0]      res_s3;
	logic             taken_s3;
	rv64ex_pkg::sel_t sel_s3;
	logic [33:0]      mid_s3;
	logic [63:0]      hi1_s3, corr_s3;
	logic [31:0]      lllo_s3;
	logic [63:0]      ma_s3, mb_s3;
	logic             negq_s3, negr_s3, dz_s3, word_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s3   <= res_s2;
			taken_s3 <= taken_s2;
			sel_s3   <= sel_s2;
			mid_s3   <= 34'(ll_s2[63:32]) + 34'(lh_s2[31:0]) + 34'(hl_s2[31:0]);
			hi1_s3   <= hh_s2 + 64'(lh_s2[63:32]) + 64'(hl_s2[63:32]);
			// signed high-word correction
			corr_s3  <= (a_s2[63] ? b_s2 : 64'd0) + (b_s2[63] ? a_s2 : 64'd0);
			lllo_s3  <= ll_s2[31:0];
			ma_s3    <= ma_s2;
			mb_s3    <= mb_s2;
			negq_s3  <= negq_s2;
			negr_s3  <= negr_s2;
			dz_s3    <= dz_s2;
			word_s3  <= word_s2;
		end
	end

	// ---------------- Stage 4 input: finish multiply, load divider ----------------
	rv64ex_pkg::div_stage_t div_in;
	logic [63:0]            mul_lo;

	always_comb begin
		mul_lo              = {mid_s3[31:0], lllo_s3};
		div_in.rem          = '0;
		div_in.qd           = ma_s3;
		div_in.dvs          = mb_s3;
		div_in.side.taken   = taken_s3;
		div_in.side.negq    = negq_s3;
		div_in.side.negr    = negr_s3;
		div_in.side.dz      = dz_s3;
		div_in.side.word    = word_s3;
		div_in.side.sel     = sel_s3;
		div_in.side.result  = res_s3;
		case (sel_s3)
			rv64ex_pkg::SEL_MUL: begin
				div_in.side.result = mul_lo;
				div_in.side.sel    = rv64ex_pkg::SEL_ALU;
			end
			rv64ex_pkg::SEL_MULH: begin
				div_in.side.result = hi1_s3 + 64'(mid_s3[33:32]) - corr_s3;
				div_in.side.sel    = rv64ex_pkg::SEL_ALU;
			end
			rv64ex_pkg::SEL_MULW: begin
				div_in.side.result = rv64ex_pkg::sext32(mul_lo);
				div_in.side.sel    = rv64ex_pkg::SEL_ALU;
			end
			default: ;
		endcase
	end

	logic                   div_valid;
	rv64ex_pkg::div_stage_t div_out;

	rv64ex_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (valid_s3),
		.in_stage  (div_in),
		.out_valid (div_valid),
		.out_stage (div_out)
	);

	// ---------------- Output stage: sign fix-up and result select ----------------
	logic [63:0] quo, rmd, fin;

	always_comb begin
		quo = div_out.side.dz   ? '1 :
		      div_out.side.negq ? (64'd0 - div_out.qd) : div_out.qd;
		rmd = div_out.side.negr ? (64'd0 - div_out.rem) : div_out.rem;
		case (div_out.side.sel)
			rv64ex_pkg::SEL_DIV:
				fin = div_out.side.word ? rv64ex_pkg::sext32(quo) : quo;
			rv64ex_pkg::SEL_REM:
				fin = div_out.side.word ? rv64ex_pkg::sext32(rmd) : rmd;
			default:
				fin = div_out.side.result;
		endcase
	end

	logic [63:0] result_q;
	logic        taken_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= fin;
			taken_q  <= div_out.side.taken;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign result       = result_q;
	assign branch_taken = taken_q;

endmodule

`default_nettype wire

// ===== rtl/core/rv64ex_checker.sv =====
// ----------------------------------------------------------------------------
// rv64ex_checker
// Port-level checks for the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rv64im_execute_unit_core_defines.svh"

module rv64ex_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_stall,
	input wire logic        rsp_valid,
	input wire logic        rsp_stall,
	input wire logic [63:0] result,
	input wire logic        branch_taken
);

	`RV64EX_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "response dropped")
	`RV64EX_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable({result, branch_taken}), "response changed")
	`RV64EX_ASSERT_NOW(a_empty_ready, !rsp_valid, !req_stall, "stalls with empty output")
	`RV64EX_ASSERT_NOW(a_drain_ready, !rsp_stall, !req_stall, "stalls while draining")

endmodule

bind rv64im_execute_unit_core rv64ex_checker u_rv64ex_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RV64IM execute unit. A directed set covers the
// RISC-V corner cases, then random instruction traffic runs with random gaps
// on the request side and random stalls on the response side. Every response
// is checked against a behavioral model of the execute stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
	import rv64ex_pkg::*;

	localparam int          RANDOM_REQS = 1625;
	localparam int          DRAIN_WAIT  = 100;   // idle margin after the last response
	localparam int          CYCLE_LIMIT = 600000;
	localparam logic [63:0] MIN64       = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX64       = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] MIN32_X     = 64'hffff_ffff_8000_0000;
	localparam logic [5:0]  CMD_TOP     = 6'h3f;  // highest code the port can carry

	typedef struct {
		logic [5:0]  cmd;
		logic [63:0] a;
		logic [63:0] b;
		logic [31:0] imm;
		logic [63:0] pc;
	} exec_req_t;

	typedef struct {
		logic [63:0] value;
		logic        taken;
	} exec_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [5:0]  cmd = '0;
	logic [63:0] operand_a = '0;
	logic [63:0] operand_b = '0;
	logic [31:0] imm = '0;
	logic [63:0] pc = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [63:0] result;
	logic        branch_taken;

	exec_req_t   pending_reqs[$];
	exec_rsp_t   expected_rsps[$];
	int          errors = 0;
	int          checked = 0;
	int          taken_seen = 0;
	int          cycles = 0;
	int          burst_left = 0;
	int          gap_left = 0;

	rv64im_execute_unit_core dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.cmd(cmd), .operand_a(operand_a), .operand_b(operand_b),
		.imm(imm), .pc(pc),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.result(result), .branch_taken(branch_taken)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Behavioral model of the execute stage
	// ---------------------------------------------------------------------
	function automatic logic [63:0] to_word(input logic [63:0] x);
		return {{32{x[31]}}, x[31:0]};
	endfunction

	// Signed divide with the RISC-V repairs: x/0 gives all ones with the
	// dividend as remainder; MIN/-1 gives MIN with zero remainder.
	function automatic void sdivide(input logic [63:0] n, input logic [63:0] d,
			output logic [63:0] q, output logic [63:0] r);
		if (d == '0) begin
			q = '1;
			r = n;
		end else if (n == MIN64 && d == '1) begin
			q = MIN64;
			r = '0;
		end else begin
			q = $signed(n) / $signed(d);
			r = $signed(n) % $signed(d);
		end
	endfunction

	function automatic exec_rsp_t exec_predict(input exec_req_t r);
		exec_rsp_t   o;
		logic [63:0] c, q, rm;
		logic [127:0] prod;
		c = {{32{r.imm[31]}}, r.imm};
		o.value = '0;
		o.taken = 1'b0;
		case (r.cmd)
			CMD_ADD:   o.value = r.a + r.b;
			CMD_MUL:   o.value = r.a * r.b;
			CMD_SUB:   o.value = r.a - r.b;
			CMD_SLL:   o.value = r.a << r.b[5:0];
			CMD_MULH: begin
				prod = $signed({{64{r.a[63]}}, r.a}) * $signed({{64{r.b[63]}}, r.b});
				o.value = prod[127:64];
			end
			CMD_SLT:   o.value = {63'd0, $signed(r.a) < $signed(r.b)};
			CMD_XOR:   o.value = r.a ^ r.b;
			CMD_DIV: begin
				sdivide(r.a, r.b, q, rm);
				o.value = q;
			end
			CMD_SRL:   o.value = r.a >> r.b[5:0];
			CMD_SRA:   o.value = $signed(r.a) >>> r.b[5:0];
			CMD_OR:    o.value = r.a | r.b;
			CMD_REM: begin
				sdivide(r.a, r.b, q, rm);
				o.value = rm;
			end
			CMD_AND:   o.value = r.a & r.b;
			CMD_ADDW:  o.value = to_word(r.a + r.b);
			CMD_SUBW:  o.value = to_word(r.a - r.b);
			CMD_MULW:  o.value = to_word(r.a * r.b);
			CMD_DIVW: begin
				sdivide(to_word(r.a), to_word(r.b), q, rm);
				o.value = to_word(q);
			end
			CMD_REMW: begin
				sdivide(to_word(r.a), to_word(r.b), q, rm);
				o.value = to_word(rm);
			end
			CMD_SLLW:  o.value = to_word(r.a << r.b[4:0]);
			CMD_SRLW:  o.value = to_word({32'd0, r.a[31:0]} >> r.b[4:0]);
			CMD_SRAW:  o.value = $signed(to_word(r.a)) >>> r.b[4:0];
			CMD_LOAD, CMD_ADDI, CMD_STORE: o.value = r.a + c;
			CMD_SLLI:  o.value = r.a << c[5:0];
			CMD_SRLI:  o.value = r.a >> c[5:0];
			CMD_SRAI:  o.value = $signed(r.a) >>> c[5:0];
			CMD_SLLIW: o.value = to_word(r.a << c[4:0]);
			CMD_SLTI:  o.value = {63'd0, $signed(r.a) < $signed(c)};
			CMD_XORI:  o.value = r.a ^ c;
			CMD_SRLIW: o.value = to_word({32'd0, r.a[31:0]} >> c[4:0]);
			CMD_SRAIW: o.value = $signed(to_word(r.a)) >>> c[4:0];
			CMD_ORI:   o.value = r.a | c;
			CMD_ANDI:  o.value = r.a & c;
			CMD_ADDIW: o.value = to_word(r.a + c);
			CMD_JALR:  o.value = (r.a + c) & ~64'd1;
			CMD_BEQ, CMD_BNE, CMD_BLT, CMD_BGE, CMD_BLTU, CMD_BGEU: begin
				o.value = r.pc + c;
				case (r.cmd)
					CMD_BEQ:  o.taken = r.a == r.b;
					CMD_BNE:  o.taken = r.a != r.b;
					CMD_BLT:  o.taken = $signed(r.a) < $signed(r.b);
					CMD_BGE:  o.taken = $signed(r.a) >= $signed(r.b);
					CMD_BLTU: o.taken = r.a < r.b;
					default:  o.taken = r.a >= r.b;
				endcase
			end
			CMD_AUIPC, CMD_JAL: o.value = r.pc + c;
			CMD_LUI:   o.value = c;
			default:   o.value = '0;   // unassigned codes
		endcase
		return o;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	// Operands lean on boundary values now and then so that compares,
	// overflow and the divide repairs get hit often.
	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return MIN64;
			3:       return MAX64;
			4:       return MIN32_X;
			5:       return 64'($signed($urandom_range(0, 64)) - 32);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic exec_req_t random_req();
		exec_req_t r;
		if ($urandom_range(0, 19) == 0)
			r.cmd = 6'($urandom_range(CMD_JAL + 1, CMD_TOP));
		else
			r.cmd = 6'($urandom_range(CMD_ADD, CMD_JAL));
		r.a = pick_value();
		// branches get equal operands some of the time
		r.b = ($urandom_range(0, 7) == 0) ? r.a : pick_value();
		r.imm = ($urandom_range(0, 3) == 0) ? 32'(pick_value()) : $urandom;
		r.pc = {$urandom, $urandom};
		return r;
	endfunction

	function automatic exec_req_t mk(input logic [5:0] c, input logic [63:0] a,
			input logic [63:0] b, input logic [31:0] i, input logic [63:0] p);
		exec_req_t r;
		r.cmd = c; r.a = a; r.b = b; r.imm = i; r.pc = p;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Request driver: bursts of random length separated by random gaps.
	// A stalled request holds its payload until it is taken.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : drive_reqs
		logic      fire;
		exec_req_t nxt;
		fire = 1'b0;
		if (arst_n) begin
			if (req_valid && !req_stall)
				expected_rsps.push_back(exec_predict(pending_reqs.pop_front()));
			if (!(req_valid && req_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() > 0) begin
					fire = 1'b1;
					nxt = pending_reqs[0];
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						// about half the bursts run back to back with no gap
						gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
					end
				end
				req_valid <= fire;
				if (fire) begin
					cmd <= nxt.cmd;
					operand_a <= nxt.a;
					operand_b <= nxt.b;
					imm <= nxt.imm;
					pc <= nxt.pc;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Response monitor and back-pressure. The stall style steps with
	// cycles[9:8] through: none, sparse random, square wave, heavy random.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : check_rsps
		exec_rsp_t exp_rsp;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d responses still owed", $time, expected_rsps.size());
			$display("status: fail");
			$finish;
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected response result=%h taken=%b",
					$time, result, branch_taken);
				errors++;
			end else begin
				exp_rsp = expected_rsps.pop_front();
				checked++;
				if (branch_taken === 1'b1)
					taken_seen++;
				if (result !== exp_rsp.value) begin
					$display("%0t: result mismatch expected=%h actual=%h",
						$time, exp_rsp.value, result);
					errors++;
				end
				if (branch_taken !== exp_rsp.taken) begin
					$display("%0t: branch_taken mismatch expected=%b actual=%b",
						$time, exp_rsp.taken, branch_taken);
					errors++;
				end
			end
		end
		case (cycles[9:8])
			2'd0:    rsp_stall <= 1'b0;
			2'd1:    rsp_stall <= ($urandom_range(0, 3) == 0);
			2'd2:    rsp_stall <= cycles[3];
			default: rsp_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed corner cases
		pending_reqs.push_back(mk(CMD_DIV,   MIN64, '1, '0, '0));      // signed overflow
		pending_reqs.push_back(mk(CMD_REM,   MIN64, '1, '0, '0));
		pending_reqs.push_back(mk(CMD_DIV,   MAX64, '0, '0, '0));      // divide by zero
		pending_reqs.push_back(mk(CMD_REM,   MIN64, '0, '0, '0));
		pending_reqs.push_back(mk(CMD_DIVW,  MIN32_X, '1, '0, '0));
		pending_reqs.push_back(mk(CMD_REMW,  64'h1234_5678_8000_0000, 64'hffff_ffff, '0, '0));
		pending_reqs.push_back(mk(CMD_DIVW,  64'h5, 64'hffff_ffff_0000_0000, '0, '0));
		pending_reqs.push_back(mk(CMD_REMW,  64'hdead_beef_8765_4321, 64'hff_0000_0000, '0, '0));
		pending_reqs.push_back(mk(CMD_MULH,  MIN64, MIN64, '0, '0));
		pending_reqs.push_back(mk(CMD_MULH,  '1, MAX64, '0, '0));
		pending_reqs.push_back(mk(CMD_SLL,   '1, 64'hffc1, '0, '0));   // shamt masked to 6 bits
		pending_reqs.push_back(mk(CMD_SRA,   MIN64, 64'h7f, '0, '0));
		pending_reqs.push_back(mk(CMD_SRLW,  64'hffff_ffff_8000_0000, 64'h20, '0, '0));
		pending_reqs.push_back(mk(CMD_SRLIW, '1, '0, 32'hffff_ffe0, '0)); // zero shift, sign kept
		pending_reqs.push_back(mk(CMD_SRAIW, 64'h8000_0000, '0, 32'h3f, '0));
		pending_reqs.push_back(mk(CMD_SLLIW, 64'h1, '0, 32'h1f, '0));
		pending_reqs.push_back(mk(CMD_JALR,  64'h1000, '0, 32'h7, '0));
		pending_reqs.push_back(mk(CMD_BEQ,   MIN64, MIN64, 32'h8000_0000, 64'h40));
		pending_reqs.push_back(mk(CMD_BLT,   MIN64, MAX64, 32'h7fff_ffff, '1));
		pending_reqs.push_back(mk(CMD_BGEU,  MIN64, MAX64, 32'hffff_fffc, '0));
		pending_reqs.push_back(mk(CMD_BLTU,  '0, '1, 32'h10, MAX64));
		pending_reqs.push_back(mk(CMD_AUIPC, '0, '0, 32'h8000_0000, 64'h7fff_ffff));
		pending_reqs.push_back(mk(CMD_LUI,   '1, '1, 32'hffff_f000, '1));
		pending_reqs.push_back(mk(CMD_JAL,   '0, '0, 32'hffff_fffe, '0));
		pending_reqs.push_back(mk(CMD_TOP,   '1, '1, '1, '1));          // unassigned code

		// let the directed set drain completely before random traffic
		wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);

		for (int n = 0; n < RANDOM_REQS; n++)
			pending_reqs.push_back(random_req());

		wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("checked %0d execute responses (%0d with branch taken),", checked, taken_seen);
		$display("all operation codes plus unassigned ones, under request gaps and stalls");
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
